FILE: hdl/svs_pkg.sv
// Shared constants and types for the sprite quad vertex setup unit.
`timescale 1ns / 1ps
package svs_pkg;

	// Beat widths on the stream ports
	localparam int IN_TDATA_W  = 200;
	localparam int OUT_TDATA_W = 96;
	localparam int OUT_TUSER_W = 3;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int SIZE_W    = 13;

	// Divider geometry: 16 quotient bits, dividend below 65536 * divisor
	localparam int QUO_W      = 16;
	localparam int DVD_W      = QUO_W + SIZE_W;
	localparam int DIV_STAGES = QUO_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIEWPORT_W = 2'd0,
		CFG_VIEWPORT_H = 2'd1,
		CFG_TEXTURE_W  = 2'd2,
		CFG_TEXTURE_H  = 2'd3
	} cfg_reg_e;

	// Vertex slots of the triangle list LT, RT, LB, LB, RT, RB
	localparam logic [OUT_TUSER_W-1:0] SLOT_LT   = 3'd0;
	localparam logic [OUT_TUSER_W-1:0] SLOT_RT0  = 3'd1;
	localparam logic [OUT_TUSER_W-1:0] SLOT_LB0  = 3'd2;
	localparam logic [OUT_TUSER_W-1:0] SLOT_LB1  = 3'd3;
	localparam logic [OUT_TUSER_W-1:0] SLOT_RT1  = 3'd4;
	localparam logic [OUT_TUSER_W-1:0] SLOT_LAST = 3'd5;

	// Corner of a slot: bit 0 = right edge, bit 1 = bottom edge
	function automatic logic [1:0] corner_of_slot(input logic [OUT_TUSER_W-1:0] slot);
		logic [1:0] c;
		case (slot)
			SLOT_LT:   c = 2'b00;
			SLOT_RT0:  c = 2'b01;
			SLOT_LB0:  c = 2'b10;
			SLOT_LB1:  c = 2'b10;
			SLOT_RT1:  c = 2'b01;
			SLOT_LAST: c = 2'b11;
			default:   c = 2'b00;
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/sprite_quad_vertex_setup_unit.sv
// Sprite quad vertex setup: six vertices per sprite, rotated, mapped to NDC and UV.
// Throughput: one vertex per cycle while the output is not stalled; a new sprite is taken
// in the cycle that the last slot of the previous one issues. The vertex issuer sends one slot
// a cycle, unless stalled, into a pipeline ending in a 16-stage divider.
// Reset clears all valid bits and loads the size registers with 1280, 720, 256, 256.
`timescale 1ns / 1ps
module sprite_quad_vertex_setup_unit #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int COORD_FRAC_BITS  = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// pos_x, pos_y, scale_x, scale_y, src_x, src_y, src_w, src_h, pivot_x, pivot_y,
	// turn, color_rgba, zero fill
	input  logic [svs_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// ndc_x, ndc_y, tex_u, tex_v, vertex_color
	output logic [svs_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// vertex_slot
	output logic [svs_pkg::OUT_TUSER_W-1:0]    m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [svs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [svs_pkg::SIZE_W-1:0]         cfg_data
);
	import svs_pkg::*;

	localparam int AX_W = ((SIZE_W + COORD_FRAC_BITS > 16) ? SIZE_W + COORD_FRAC_BITS : 16) + 2;
	localparam int DX_W = AX_W + 16;
	localparam int PR_W = DX_W + 16;
	localparam int X_W  = ((PR_W > 42) ? PR_W : 42) + 2;
	localparam int NSH  = COORD_FRAC_BITS + 11;
	localparam int NS_W = ((X_W - NSH > 30) ? X_W - NSH : 30) + 2;
	// texel edge: src + size reaches 4095 + 8191
	localparam int TX_W = SIZE_W + 1;

	typedef struct packed {
		logic [31:0]            color;
		logic [OUT_TUSER_W-1:0] slot;
		logic                   last;
	} side_t;

	typedef struct packed {
		logic  x_lo, x_hi, y_lo, y_hi, u_sat, v_sat;
		side_t side;
	} flag_t;

	// Size registers
	logic [SIZE_W-1:0] vp_w_q, vp_h_q, tx_w_q, tx_h_q;
	logic [SIZE_W-1:0] vp_w_fix, vp_h_fix, tx_w_fix, tx_h_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_w_q <= SIZE_W'(1280);
			vp_h_q <= SIZE_W'(720);
			tx_w_q <= SIZE_W'(256);
			tx_h_q <= SIZE_W'(256);
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				CFG_VIEWPORT_W: vp_w_q <= cfg_data;
				CFG_VIEWPORT_H: vp_h_q <= cfg_data;
				CFG_TEXTURE_W:  tx_w_q <= cfg_data;
				CFG_TEXTURE_H:  tx_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A size of zero counts as one
	assign vp_w_fix = (vp_w_q == '0) ? SIZE_W'(1) : vp_w_q;
	assign vp_h_fix = (vp_h_q == '0) ? SIZE_W'(1) : vp_h_q;
	assign tx_w_fix = (tx_w_q == '0) ? SIZE_W'(1) : tx_w_q;
	assign tx_h_fix = (tx_h_q == '0) ? SIZE_W'(1) : tx_h_q;

	// Pipeline advance: stalls only when the output beat is held
	logic en;
	logic m_tvalid_q;
	assign en = !m_tvalid_q || m_tready;

	// Sprite holding register and slot issuer
	logic                   hold_vld_q;
	logic [OUT_TUSER_W-1:0] slot_q;
	logic signed [15:0]     pos_x_q, pos_y_q, scale_x_q, scale_y_q, pivot_x_q, pivot_y_q;
	logic [11:0]            src_x_q, src_y_q;
	logic [SIZE_W-1:0]      src_w_q, src_h_q;
	logic [15:0]            turn_q;
	logic [31:0]            color_q;
	logic                   in_acc;

	assign s_tready = !hold_vld_q || (en && slot_q == SLOT_LAST);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			slot_q     <= SLOT_LT;
		end else begin
			if (en && hold_vld_q) begin
				if (slot_q == SLOT_LAST) begin
					hold_vld_q <= 1'b0;
					slot_q     <= SLOT_LT;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (in_acc) begin
				hold_vld_q <= 1'b1;
				slot_q     <= SLOT_LT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_x_q   <= s_tdata[15:0];
			pos_y_q   <= s_tdata[31:16];
			scale_x_q <= s_tdata[47:32];
			scale_y_q <= s_tdata[63:48];
			src_x_q   <= s_tdata[75:64];
			src_y_q   <= s_tdata[87:76];
			src_w_q   <= s_tdata[100:88];
			src_h_q   <= s_tdata[113:101];
			pivot_x_q <= s_tdata[129:114];
			pivot_y_q <= s_tdata[145:130];
			turn_q    <= s_tdata[161:146];
			color_q   <= s_tdata[193:162];
		end
	end

	// Stage 1: corner offsets in texels and texel edges
	logic [1:0]              corner;
	logic                    v_s1;
	logic signed [AX_W-1:0]  ax_s1, ay_s1;
	logic signed [15:0]      sx_s1, sy_s1, px_s1, py_s1;
	logic [TX_W-1:0]         tu_s1, tv_s1;
	logic [15:0]             turn_s1;
	side_t                   side_s1;

	assign corner = corner_of_slot(slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= hold_vld_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= (corner[0] ? (AX_W'(src_w_q) << COORD_FRAC_BITS) : AX_W'(0))
				- AX_W'(pivot_x_q);
			ay_s1 <= (corner[1] ? (AX_W'(src_h_q) << COORD_FRAC_BITS) : AX_W'(0))
				- AX_W'(pivot_y_q);
			sx_s1 <= scale_x_q;
			sy_s1 <= scale_y_q;
			px_s1 <= pos_x_q;
			py_s1 <= pos_y_q;
			tu_s1 <= corner[0] ? TX_W'(src_x_q) + TX_W'(src_w_q) : TX_W'(src_x_q);
			tv_s1 <= corner[1] ? TX_W'(src_y_q) + TX_W'(src_h_q) : TX_W'(src_y_q);
			turn_s1 <= turn_q;
			side_s1 <= '{color: color_q, slot: slot_q, last: (slot_q == SLOT_LAST)};
		end
	end

	// Sine and cosine, valid alongside stage 3
	logic signed [15:0] sin_val, cos_val;

	svs_sincos #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_sincos (
		.clk     (clk),
		.en      (en),
		.turn    (turn_s1),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	// Stage 2: scaled offsets
	logic                   v_s2, v_s3;
	logic signed [DX_W-1:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [15:0]     px_s2, py_s2, px_s3, py_s3;
	logic [TX_W-1:0]        tu_s2, tv_s2, tu_s3, tv_s3;
	side_t                  side_s2, side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2   <= DX_W'(ax_s1) * DX_W'(sx_s1);
			dy_s2   <= DX_W'(ay_s1) * DX_W'(sy_s1);
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			tu_s2   <= tu_s1;
			tv_s2   <= tv_s1;
			side_s2 <= side_s1;
			// stage 3 waits for the ROM
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			tu_s3   <= tu_s2;
			tv_s3   <= tv_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: rotation products
	logic                   v_s4;
	logic signed [PR_W-1:0] xc_s4, ys_s4, xs_s4, yc_s4;
	logic signed [15:0]     px_s4, py_s4;
	logic [TX_W-1:0]        tu_s4, tv_s4;
	side_t                  side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s4   <= PR_W'(dx_s3) * PR_W'(cos_val);
			ys_s4   <= PR_W'(dy_s3) * PR_W'(sin_val);
			xs_s4   <= PR_W'(dx_s3) * PR_W'(sin_val);
			yc_s4   <= PR_W'(dy_s3) * PR_W'(cos_val);
			px_s4   <= px_s3;
			py_s4   <= py_s3;
			tu_s4   <= tu_s3;
			tv_s4   <= tv_s3;
			side_s4 <= side_s3;
		end
	end

	// Stage 5: rotated corner about the anchor
	logic                  v_s5;
	logic signed [X_W-1:0] x_s5, y_s5;
	logic [TX_W-1:0]       tu_s5, tv_s5;
	side_t                 side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s5    <= (X_W'(px_s4) <<< 26) + X_W'(xc_s4) - X_W'(ys_s4);
			y_s5    <= (X_W'(py_s4) <<< 26) + X_W'(xs_s4) + X_W'(yc_s4);
			tu_s5   <= tu_s4;
			tv_s5   <= tv_s4;
			side_s5 <= side_s4;
		end
	end

	// Stage 6: rounded dividend, offset so that the quotient is ndc + 32768
	// half a divisor step is added before the low bits are dropped
	logic                   v_s6;
	logic signed [NS_W-1:0] nx_s6, ny_s6;
	logic [TX_W-1:0]        tu_s6, tv_s6;
	side_t                  side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s6 <= NS_W'((x_s5 + $signed(X_W'(vp_w_fix) << (NSH - 1))) >>> NSH)
				+ NS_W'({vp_w_fix, 14'b0});
			ny_s6 <= NS_W'((y_s5 + $signed(X_W'(vp_h_fix) << (NSH - 1))) >>> NSH)
				+ NS_W'({vp_h_fix, 14'b0});
			tu_s6   <= tu_s5;
			tv_s6   <= tv_s5;
			side_s6 <= side_s5;
		end
	end

	// Stage 7: saturation flags and divider operands
	logic             v_s7;
	logic [DVD_W-1:0] dvd_x_s7, dvd_y_s7, dvd_u_s7, dvd_v_s7;
	flag_t            flag_s7;
	logic [DVD_W-1:0] mu, mv;

	assign mu = {1'b0, tu_s6, 14'b0} + DVD_W'(tx_w_fix >> 1);
	assign mv = {1'b0, tv_s6, 14'b0} + DVD_W'(tx_h_fix >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_x_s7 <= nx_s6[DVD_W-1:0];
			dvd_y_s7 <= ny_s6[DVD_W-1:0];
			dvd_u_s7 <= mu;
			dvd_v_s7 <= mv;
			flag_s7.x_lo  <= nx_s6[NS_W-1];
			flag_s7.x_hi  <= !nx_s6[NS_W-1] && (nx_s6 >= NS_W'({vp_w_fix, 16'b0}));
			flag_s7.y_lo  <= ny_s6[NS_W-1];
			flag_s7.y_hi  <= !ny_s6[NS_W-1] && (ny_s6 >= NS_W'({vp_h_fix, 16'b0}));
			flag_s7.u_sat <= mu >= {tx_w_fix, 16'b0};
			flag_s7.v_sat <= mv >= {tx_h_fix, 16'b0};
			flag_s7.side  <= side_s6;
		end
	end

	// Dividers
	logic [QUO_W-1:0] qx, qy, qu, qv;

	svs_div u_div_x (.clk(clk), .en(en), .dividend(dvd_x_s7), .divisor(vp_w_fix), .quotient(qx));
	svs_div u_div_y (.clk(clk), .en(en), .dividend(dvd_y_s7), .divisor(vp_h_fix), .quotient(qy));
	svs_div u_div_u (.clk(clk), .en(en), .dividend(dvd_u_s7), .divisor(tx_w_fix), .quotient(qu));
	svs_div u_div_v (.clk(clk), .en(en), .dividend(dvd_v_s7), .divisor(tx_h_fix), .quotient(qv));

	// Flags and valid bits beside the divider stages
	logic  v_d_q [DIV_STAGES];
	flag_t flag_d_q [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) v_d_q[i] <= 1'b0;
		end else if (en) begin
			v_d_q[0] <= v_s7;
			for (int i = 1; i < DIV_STAGES; i++) v_d_q[i] <= v_d_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flag_d_q[0] <= flag_s7;
			for (int i = 1; i < DIV_STAGES; i++) flag_d_q[i] <= flag_d_q[i-1];
		end
	end

	// Final saturation and output register
	flag_t       fo;
	logic [15:0] ndc_x, ndc_y, ty, tex_u, tex_v;

	assign fo    = flag_d_q[DIV_STAGES-1];
	assign ndc_x = fo.x_lo ? 16'h8000 : (fo.x_hi ? 16'h7FFF : {~qx[15], qx[14:0]});
	assign ty    = {~qy[15], qy[14:0]};
	assign ndc_y = (fo.y_lo || ty == 16'h8000) ? 16'h7FFF : (fo.y_hi ? 16'h8000 : -ty);
	assign tex_u = fo.u_sat ? 16'hFFFF : qu;
	assign tex_v = fo.v_sat ? 16'hFFFF : qv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (en) m_tvalid_q <= v_d_q[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {fo.side.color, tex_v, tex_u, ndc_y, ndc_x};
			m_tuser <= fo.side.slot;
			m_tlast <= fo.side.last;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

FILE: hdl/svs_sincos.sv
// Sine and cosine of a binary angle from a quarter-wave ROM, two register stages.
`timescale 1ns / 1ps
module svs_sincos #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        turn,
	output logic signed [15:0] sin_val,
	output logic signed [15:0] cos_val
);
	import svs_pkg::*;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PROD_W = 14 + ADDR_W;

	// Taylor denominators (2n)(2n+1)
	localparam longint unsigned TAYLOR_DEN [1:12] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	typedef logic [14:0] tab_t [SINE_TABLE_DEPTH + 1];

	// Quarter-wave table, Q1.14, Taylor series in Q.30 worked out at elaboration
	function automatic tab_t build_tab();
		tab_t            tab;
		longint unsigned x;
		longint unsigned t;
		longint          sum;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x   = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			t   = x;
			sum = longint'(x);
			for (int n = 1; n <= 12; n++) begin
				t = (t * x) >> 30;
				t = (t * x) >> 30;
				t = t / TAYLOR_DEN[n];
				if (n % 2 == 1) sum = sum - longint'(t);
				else sum = sum + longint'(t);
			end
			if (sum < 0) sum = 0;
			tab[k] = 15'((sum + 32768) >>> 16);
		end
		return tab;
	endfunction

	localparam tab_t SIN_TAB = build_tab();

	logic [15:0]        cos_turn;
	logic [PROD_W-1:0]  sin_prod, cos_prod;
	logic [ADDR_W-1:0]  sin_idx, cos_idx;
	logic [ADDR_W-1:0]  sin_addr_s1, cos_addr_s1;
	logic               sin_neg_s1, cos_neg_s1;
	logic [14:0]        sin_rom_s2, cos_rom_s2;
	logic               sin_neg_s2, cos_neg_s2;

	// Table index and quadrant folding
	assign cos_turn = turn + 16'h4000;
	assign sin_prod = PROD_W'(turn[13:0]) * PROD_W'(SINE_TABLE_DEPTH);
	assign cos_prod = PROD_W'(cos_turn[13:0]) * PROD_W'(SINE_TABLE_DEPTH);
	assign sin_idx  = sin_prod[14 +: ADDR_W];
	assign cos_idx  = cos_prod[14 +: ADDR_W];

	always_ff @(posedge clk) begin
		if (en) begin
			sin_addr_s1 <= turn[14] ? ADDR_W'(SINE_TABLE_DEPTH) - sin_idx : sin_idx;
			cos_addr_s1 <= cos_turn[14] ? ADDR_W'(SINE_TABLE_DEPTH) - cos_idx : cos_idx;
			sin_neg_s1  <= turn[15];
			cos_neg_s1  <= cos_turn[15];
		end
	end

	// ROM read, two ports, registered
	always_ff @(posedge clk) begin
		if (en) begin
			sin_rom_s2 <= SIN_TAB[sin_addr_s1];
			cos_rom_s2 <= SIN_TAB[cos_addr_s1];
			sin_neg_s2 <= sin_neg_s1;
			cos_neg_s2 <= cos_neg_s1;
		end
	end

	// Sign of the quadrant
	assign sin_val = sin_neg_s2 ? -$signed({1'b0, sin_rom_s2}) : $signed({1'b0, sin_rom_s2});
	assign cos_val = cos_neg_s2 ? -$signed({1'b0, cos_rom_s2}) : $signed({1'b0, cos_rom_s2});

endmodule

FILE: hdl/svs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module svs_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [svs_pkg::DVD_W-1:0]    dividend,
	input  logic [svs_pkg::SIZE_W-1:0]   divisor,
	output logic [svs_pkg::QUO_W-1:0]    quotient
);
	import svs_pkg::*;

	logic [DVD_W-1:0]  rem_s [DIV_STAGES];
	logic [SIZE_W-1:0] dvs_s [DIV_STAGES];
	logic [QUO_W-1:0]  quo_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_bit
		logic [DVD_W-1:0]  rem_in;
		logic [SIZE_W-1:0] dvs_in;
		logic [QUO_W-1:0]  quo_in;
		logic [DVD_W:0]    trial;

		if (k == 0) begin : g_first
			assign rem_in = dividend;
			assign dvs_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// Trial subtract of the divisor at this bit weight
		assign trial = {1'b0, rem_in} - ((DVD_W + 1)'(dvs_in) << (QUO_W - 1 - k));

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= trial[DVD_W] ? rem_in : trial[DVD_W-1:0];
				dvs_s[k] <= dvs_in;
				quo_s[k] <= {quo_in[QUO_W-2:0], ~trial[DVD_W]};
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES-1];

endmodule

FILE: hdl/svs_checker.sv
// Port-level checks on the vertex stream, bound to the top level.
`timescale 1ns / 1ps
module svs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [svs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [svs_pkg::OUT_TUSER_W-1:0] m_tuser,
	input logic                            m_tlast
);
	import svs_pkg::*;

	// A held beat keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// Last flag marks the sixth vertex and nothing else
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == SLOT_LAST)))
		else $error("tlast does not match vertex slot");

	// Slot stays within the six vertices
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= SLOT_LAST))
		else $error("vertex slot out of range");

	// Both left-bottom vertices carry the same data
	a_lb: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tuser == SLOT_LB0) ##1 (m_tvalid && m_tuser == SLOT_LB1)
		|-> m_tdata == $past(m_tdata))
		else $error("repeated left-bottom vertex differs");

endmodule

bind sprite_quad_vertex_setup_unit svs_checker u_svs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: tb/sprite_quad_vertex_setup_unit_tb.sv
// Self-checking testbench for the sprite quad vertex setup unit.
`timescale 1ns / 1ps
module sprite_quad_vertex_setup_unit_tb;
	import svs_pkg::*;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int TABLE_DEPTH = 1024;
	localparam int FRAC = 4;

	typedef struct {
		logic signed [15:0] pos_x, pos_y, scale_x, scale_y;
		logic [11:0] src_x, src_y;
		logic [12:0] src_w, src_h;
		logic signed [15:0] pivot_x, pivot_y;
		logic [15:0] turn;
		logic [31:0] color;
	} sprite_t;

	typedef struct {
		logic signed [15:0] ndc_x, ndc_y;
		logic [15:0] tex_u, tex_v;
		logic [31:0] color;
		logic [2:0] slot;
		logic last;
	} vertex_t;

	typedef struct {
		sprite_t spr;
		bit typed;
		logic [15:0] ndc_x, ndc_y, tex_u, tex_v;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	cfg_reg_e cfg_index = CFG_VIEWPORT_W;
	logic [SIZE_W-1:0] cfg_data = '0;

	// Local copy of the size registers
	logic [SIZE_W-1:0] vp_w = 13'd1280, vp_h = 13'd720, tx_w = 13'd256, tx_h = 13'd256;

	longint sine_lut [0:TABLE_DEPTH];
	vertex_t pending_vertices [$];
	int fault_count = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit hold_req = 1'b0;
	stim_row_t rows [$];

	sprite_quad_vertex_setup_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("sprite_quad_vertex_setup_unit: mismatch");
		$finish;
	end

	// Quarter-wave entry by integer Taylor series, Q.30 rounded to Q1.14
	function automatic longint quarter_sine(longint unsigned k);
		longint unsigned x, t;
		longint acc;
		x = (k * HALF_PI_Q30) / TABLE_DEPTH;
		t = x;
		acc = longint'(x);
		for (int n = 1; n <= 12; n++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / ((2 * n) * (2 * n + 1));
			if (n % 2 == 1) acc -= longint'(t);
			else acc += longint'(t);
		end
		if (acc < 0) acc = 0;
		return (acc + 32768) >>> 16;
	endfunction

	function automatic longint angle_sine(logic [15:0] a);
		longint unsigned idx;
		longint v;
		idx = (longint'(a[13:0]) * TABLE_DEPTH) >> 14;
		v = a[14] ? sine_lut[TABLE_DEPTH - idx] : sine_lut[idx];
		return a[15] ? -v : v;
	endfunction

	// floor(a / d + 1/2), d > 0
	function automatic longint round_div(longint a, longint d);
		longint n, dd;
		n = 2 * a + d;
		dd = 2 * d;
		if (n >= 0) return n / dd;
		return -((-n + dd - 1) / dd);
	endfunction

	function automatic logic [15:0] clamp_s16(longint v);
		if (v > 32767) return 16'h7fff;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic logic [15:0] uv_coord(longint unsigned texel, logic [SIZE_W-1:0] size);
		longint unsigned s, r;
		s = (size == 0) ? 1 : size;
		r = (2 * texel * 16384 + s) / (2 * s);
		return (r > 65535) ? 16'hffff : r[15:0];
	endfunction

	// Six vertices of one sprite under the current sizes
	function automatic void predict_quad(sprite_t p);
		logic [1:0] corner [6] = '{2'b00, 2'b01, 2'b10, 2'b10, 2'b01, 2'b11};
		longint sn, cs, xl, xr, yt, yb, dw, dh, dx, dy, cx, cy;
		logic [15:0] nx [4], ny [4], u0, u1, v0, v1;
		vertex_t vx;
		sn = angle_sine(p.turn);
		cs = angle_sine(p.turn + 16'h4000);
		xl = -longint'(p.pivot_x) * p.scale_x;
		xr = (longint'(p.src_w) * (1 << FRAC) - p.pivot_x) * p.scale_x;
		yt = -longint'(p.pivot_y) * p.scale_y;
		yb = (longint'(p.src_h) * (1 << FRAC) - p.pivot_y) * p.scale_y;
		dw = longint'((vp_w == 0) ? 13'd1 : vp_w) <<< (FRAC + 11);
		dh = longint'((vp_h == 0) ? 13'd1 : vp_h) <<< (FRAC + 11);
		u0 = uv_coord(p.src_x, tx_w);
		u1 = uv_coord(longint'(p.src_x) + p.src_w, tx_w);
		v0 = uv_coord(p.src_y, tx_h);
		v1 = uv_coord(longint'(p.src_y) + p.src_h, tx_h);
		for (int k = 0; k < 4; k++) begin
			dx = k[0] ? xr : xl;
			dy = k[1] ? yb : yt;
			cx = (longint'(p.pos_x) <<< 26) + dx * cs - dy * sn;
			cy = (longint'(p.pos_y) <<< 26) + dx * sn + dy * cs;
			nx[k] = clamp_s16(round_div(cx, dw) - 16384);
			ny[k] = clamp_s16(16384 - round_div(cy, dh));
		end
		for (int k = 0; k < 6; k++) begin
			vx.ndc_x = nx[corner[k]];
			vx.ndc_y = ny[corner[k]];
			vx.tex_u = corner[k][0] ? u1 : u0;
			vx.tex_v = corner[k][1] ? v1 : v0;
			vx.color = p.color;
			vx.slot = k[2:0];
			vx.last = (k == 5);
			pending_vertices = {pending_vertices, vx};
		end
	endfunction

	function automatic sprite_t make_sprite(int px, int py, int sx, int sy, int srx, int sry,
			int sw, int sh, int pvx, int pvy, int tn, logic [31:0] col);
		sprite_t p;
		p.pos_x = 16'(px); p.pos_y = 16'(py); p.scale_x = 16'(sx); p.scale_y = 16'(sy);
		p.src_x = 12'(srx); p.src_y = 12'(sry); p.src_w = 13'(sw); p.src_h = 13'(sh);
		p.pivot_x = 16'(pvx); p.pivot_y = 16'(pvy); p.turn = 16'(tn); p.color = col;
		return p;
	endfunction

	// Most sprites plausible, the rest raw bits
	function automatic sprite_t random_sprite();
		sprite_t p;
		p = make_sprite($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if ($urandom_range(0, 9) < 7) begin
			p.scale_x = 16'($urandom_range(0, 16384) - 8192);
			p.scale_y = 16'($urandom_range(0, 16384) - 8192);
			p.src_w = 13'($urandom_range(0, 256));
			p.src_h = 13'($urandom_range(0, 256));
			p.pivot_x = 16'($urandom_range(0, p.src_w * 16));
			p.pivot_y = 16'($urandom_range(0, p.src_h * 16));
			p.pos_x = 16'($urandom_range(0, 24000));
			p.pos_y = 16'($urandom_range(0, 16000));
		end
		return p;
	endfunction

	function automatic int gap_len();
		int r;
		if (tx_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// One sprite beat; valid stays high when the next follows back to back
	task automatic send_sprite(sprite_t p, bit typed, stim_row_t row);
		int gap;
		vertex_t vx;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, p.color, p.turn, p.pivot_y, p.pivot_x, p.src_h, p.src_w,
			p.src_y, p.src_x, p.scale_y, p.scale_x, p.pos_y, p.pos_x};
		do @(posedge clk); while (!s_tready);
		if (typed) begin
			for (int k = 0; k < 6; k++) begin
				vx.ndc_x = row.ndc_x; vx.ndc_y = row.ndc_y;
				vx.tex_u = row.tex_u; vx.tex_v = row.tex_v;
				vx.color = p.color; vx.slot = k[2:0]; vx.last = (k == 5);
				pending_vertices = {pending_vertices, vx};
			end
		end else begin
			predict_quad(p);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_sizes(int w, int h, int tw, int th);
		int vals [4] = '{w, h, tw, th};
		cfg_reg_e regs [4] = '{CFG_VIEWPORT_W, CFG_VIEWPORT_H, CFG_TEXTURE_W, CFG_TEXTURE_H};
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= SIZE_W'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		vp_w = SIZE_W'(w); vp_h = SIZE_W'(h); tx_w = SIZE_W'(tw); tx_h = SIZE_W'(th);
	endtask

	task automatic random_run(int count);
		stim_row_t none;
		for (int i = 0; i < count; i++) send_sprite(random_sprite(), 1'b0, none);
	endtask

	// Receiver: random stalls, a long hold-off on request
	initial begin
		int stall_left, hold_left;
		bit rdy;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if (!rx_calm && $urandom_range(0, 5) == 0)
					stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
						: $urandom_range(1, 3);
			end
			m_tready <= rdy;
		end
	end

	// Vertex beat checker
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t: vertex beat with none expected: tdata %h slot %0d", $time,
					m_tdata, m_tuser);
				fault_count++;
			end else begin
				want = pending_vertices.pop_front();
				if (m_tdata[15:0] !== want.ndc_x) begin
					$display("%0t: ndc_x expected %0d got %0d", $time, want.ndc_x,
						$signed(m_tdata[15:0]));
					fault_count++;
				end
				if (m_tdata[31:16] !== want.ndc_y) begin
					$display("%0t: ndc_y expected %0d got %0d", $time, want.ndc_y,
						$signed(m_tdata[31:16]));
					fault_count++;
				end
				if (m_tdata[47:32] !== want.tex_u) begin
					$display("%0t: tex_u expected %0d got %0d", $time, want.tex_u,
						m_tdata[47:32]);
					fault_count++;
				end
				if (m_tdata[63:48] !== want.tex_v) begin
					$display("%0t: tex_v expected %0d got %0d", $time, want.tex_v,
						m_tdata[63:48]);
					fault_count++;
				end
				if (m_tdata[95:64] !== want.color) begin
					$display("%0t: vertex_color expected %h got %h", $time, want.color,
						m_tdata[95:64]);
					fault_count++;
				end
				if (m_tuser !== want.slot) begin
					$display("%0t: vertex_slot expected %0d got %0d", $time, want.slot,
						m_tuser);
					fault_count++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last expected %0d got %0d", $time, want.last, m_tlast);
					fault_count++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		stim_row_t r;
		for (int k = 0; k <= TABLE_DEPTH; k++) sine_lut[k] = quarter_sine(k);

		// degenerate sprite at origin, corners coincide
		r = '{make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h11223344), 1'b1,
			16'hc000, 16'h4000, 16'h0000, 16'h0000};
		rows = {rows, r};
		// far corner of the screen and texture, all saturating
		r = '{make_sprite(32767, 32767, 0, 0, 4095, 4095, 4096, 4096, 0, 0, 0, 32'hffffffff),
			1'b1, 16'h7fff, 16'h8000, 16'hffff, 16'hffff};
		rows = {rows, r};
		r = '{make_sprite(-32768, -32768, 0, 0, 4095, 4095, 0, 0, 0, 0, 0, 32'h0),
			1'b1, 16'h8000, 16'h7fff, 16'hffff, 16'hffff};
		rows = {rows, r};
		r.typed = 1'b0;
		// quadrant boundaries and the top of the angle range
		for (int q = 0; q < 7; q++) begin
			r.spr = make_sprite(10240, 5760, 4096, 4096, 16, 32, 64, 48, 512, 384,
				(q < 4) ? q * 16384 : ((q == 4) ? 65535 : ((q == 5) ? 1 : 8192)),
				32'hdeadbeef);
			rows = {rows, r};
		end
		// extremes of scale, pivot and rectangle
		r.spr = make_sprite(10240, 5760, 32767, -32768, 0, 0, 4096, 4096, 32767, -32768,
			12345, 32'h01020304);
		rows = {rows, r};
		r.spr = make_sprite(0, 0, -32768, 32767, 4095, 0, 8191, 8191, -32768, 32767,
			50000, 32'h80808080);
		rows = {rows, r};
		r.spr = make_sprite(20000, -3000, -4096, -4096, 100, 200, 1, 1, 0, 0, 3000,
			32'h7f7f7f7f);
		rows = {rows, r};
		r.spr = make_sprite(-1, 1, 8192, 2048, 0, 4095, 0, 4096, -16, 16, 40000, 32'h5a5a5a5a);
		rows = {rows, r};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[i]) send_sprite(rows[i].spr, rows[i].typed, rows[i]);
		random_run(40);

		// receiver holds off while sprites keep coming
		hold_req = 1'b1;
		random_run(60);
		drain();

		write_sizes(1, 1, 1, 1);
		random_run(50);
		write_sizes(8191, 8191, 8191, 8191);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		random_run(60);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		write_sizes(0, 0, 0, 0);
		random_run(40);
		write_sizes($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(1, 4096));
		random_run(60);
		write_sizes(1920, 1080, 4096, 4096);
		random_run(60);
		write_sizes($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191),
			$urandom_range(0, 8191));
		random_run(40);

		drain();
		repeat (40) @(posedge clk);
		if (fault_count == 0)
			$display("sprite_quad_vertex_setup_unit: match");
		else
			$display("sprite_quad_vertex_setup_unit: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
hdl/svs_pkg.sv
hdl/svs_sincos.sv
hdl/svs_div.sv
hdl/sprite_quad_vertex_setup_unit.sv
hdl/svs_checker.sv
tb/sprite_quad_vertex_setup_unit_tb.sv
